### hw/rtl/x86_add_sub_flags_alu_defines.svh
// Assertion macros for the add/sub flags ALU checker.
// Included by hw/rtl/xasf_chk.sv; depends on nothing else.
`ifndef X86_ADD_SUB_FLAGS_ALU_DEFINES_SVH
`define X86_ADD_SUB_FLAGS_ALU_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define XASF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("xasf assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define XASF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xasf implication failed");

`endif

### hw/rtl/xasf_pkg.sv
// Package for the x86 add/sub flags ALU: widths, operation and size codes, item types.
// Used by the interfaces, the stage and datapath modules, the top level and the testbench; depends on nothing.
`default_nettype none

package xasf_pkg;

    localparam int DATA_W = 64;
    localparam int MODE_W = 3;
    localparam int SIZE_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SBB  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CMP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_XADD = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_64 = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size_code;
        logic [DATA_W-1:0] dst_value;
        logic [DATA_W-1:0] src_value;
        logic              carry_in;
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] src_writeback;
        logic              write_dest;
        logic              write_src;
        logic              flag_carry;
        logic              flag_overflow;
        logic              flag_aux;
        logic              flag_sign;
        logic              flag_zero;
        logic              flag_parity;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/xasf_cmd_if.sv
// Command channel interface: valid/ready plus the operands of one instruction.
// Depends on xasf_pkg.
`default_nettype none

interface xasf_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [xasf_pkg::MODE_W-1:0]  mode;
    logic [xasf_pkg::SIZE_W-1:0]  size_code;
    logic [xasf_pkg::DATA_W-1:0]  dst_value;
    logic [xasf_pkg::DATA_W-1:0]  src_value;
    logic                         carry_in;

    modport source (output valid, mode, size_code, dst_value, src_value, carry_in,
                    input ready);
    modport sink   (input valid, mode, size_code, dst_value, src_value, carry_in,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/xasf_rsp_if.sv
// Response channel interface: valid/ready plus the result and flags of one instruction.
// Depends on xasf_pkg.
`default_nettype none

interface xasf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [xasf_pkg::DATA_W-1:0]  result;
    logic [xasf_pkg::DATA_W-1:0]  src_writeback;
    logic                         write_dest;
    logic                         write_src;
    logic                         flag_carry;
    logic                         flag_overflow;
    logic                         flag_aux;
    logic                         flag_sign;
    logic                         flag_zero;
    logic                         flag_parity;

    modport source (output valid, result, src_writeback, write_dest, write_src,
                    flag_carry, flag_overflow, flag_aux, flag_sign, flag_zero,
                    flag_parity,
                    input ready);
    modport sink   (input valid, result, src_writeback, write_dest, write_src,
                    flag_carry, flag_overflow, flag_aux, flag_sign, flag_zero,
                    flag_parity,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/x86_add_sub_flags_alu.sv
// Top level of the x86 add/sub/cmp/xadd ALU with flags.
// Depends on xasf_pkg, xasf_cmd_if, xasf_rsp_if, xasf_in_stage, xasf_exec, xasf_out_stage.
//
//   channel | dir | carries
//   --------+-----+--------------------------------------------------------
//   cmd     | in  | mode, size_code, dst_value, src_value, carry_in
//   rsp     | out | result, src_writeback, write_dest, write_src, 6 flags
//
// One item per cycle sustained while rsp is not stalled; each item passes from cmd through the
// operand register, then one 65-bit add and flag logic, into the result register and out on rsp.
// Reset clears both valid bits; nothing else needs initializing.
// A stall on rsp fills the result register, then the operand register, then drops cmd.ready.
`default_nettype none

module x86_add_sub_flags_alu (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xasf_cmd_if.sink   cmd,
    xasf_rsp_if.source rsp
);

    xasf_pkg::op_t  op;
    xasf_pkg::res_t res;
    logic           op_valid;
    logic           op_ready;

    xasf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .op       (op),
        .op_valid (op_valid),
        .op_ready (op_ready)
    );

    xasf_exec u_exec (
        .op  (op),
        .res (res)
    );

    xasf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (op_valid),
        .res_ready (op_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### hw/rtl/xasf_in_stage.sv
// Input register stage: captures one command item and holds it until the next stage takes it.
// Depends on xasf_pkg and xasf_cmd_if.
`default_nettype none

module xasf_in_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    xasf_cmd_if.sink      cmd,
    output xasf_pkg::op_t op,
    output logic          op_valid,
    input  wire logic     op_ready
);

    xasf_pkg::op_t op_reg;
    logic          valid_reg;
    logic          valid_next;
    logic          load;

    assign cmd.ready  = !valid_reg || op_ready;
    assign load       = cmd.valid && cmd.ready;
    assign valid_next = load || (valid_reg && !op_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the operands while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg.mode      <= cmd.mode;
            op_reg.size_code <= cmd.size_code;
            op_reg.dst_value <= cmd.dst_value;
            op_reg.src_value <= cmd.src_value;
            op_reg.carry_in  <= cmd.carry_in;
        end
    end

    assign op       = op_reg;
    assign op_valid = valid_reg;

endmodule

`default_nettype wire

### hw/rtl/xasf_exec.sv
// Combinational add/sub datapath: one 65-bit add, width masking and flag derivation.
// Depends on xasf_pkg.
`default_nettype none

module xasf_exec (
    input  wire xasf_pkg::op_t op,
    output xasf_pkg::res_t     res
);

    logic [xasf_pkg::DATA_W-1:0] mask;
    logic [xasf_pkg::DATA_W-1:0] a;
    logic [xasf_pkg::DATA_W-1:0] b;
    logic [xasf_pkg::DATA_W-1:0] b2;
    logic [xasf_pkg::DATA_W-1:0] r;
    logic [xasf_pkg::DATA_W:0]   sum;
    logic                        use_carry;
    logic                        subtract;
    logic                        is_xadd;
    logic                        writes;
    logic                        cin;
    logic                        carry_out;
    logic                        sa;
    logic                        sb;
    logic                        sr;

    always_comb
    begin
        case (op.size_code)
            xasf_pkg::SIZE_8:  mask = 64'h0000_0000_0000_00FF;
            xasf_pkg::SIZE_16: mask = 64'h0000_0000_0000_FFFF;
            xasf_pkg::SIZE_32: mask = 64'h0000_0000_FFFF_FFFF;
            default:           mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    end

    assign use_carry = (op.mode == xasf_pkg::MODE_ADC) || (op.mode == xasf_pkg::MODE_SBB);
    assign subtract  = (op.mode == xasf_pkg::MODE_SUB) || (op.mode == xasf_pkg::MODE_SBB)
                    || (op.mode == xasf_pkg::MODE_CMP);
    assign is_xadd   = (op.mode == xasf_pkg::MODE_XADD);
    assign writes    = (op.mode == xasf_pkg::MODE_ADD) || (op.mode == xasf_pkg::MODE_ADC)
                    || (op.mode == xasf_pkg::MODE_SUB) || (op.mode == xasf_pkg::MODE_SBB)
                    || is_xadd;

    assign a   = op.dst_value & mask;
    assign b   = op.src_value & mask;
    assign b2  = subtract ? (~b & mask) : b;
    assign cin = use_carry ? (op.carry_in ^ subtract) : subtract;
    assign sum = {1'b0, a} + {1'b0, b2} + {{xasf_pkg::DATA_W{1'b0}}, cin};
    assign r   = sum[xasf_pkg::DATA_W-1:0] & mask;

    always_comb
    begin
        case (op.size_code)
            xasf_pkg::SIZE_8:
            begin
                carry_out = sum[8];
                sa        = a[7];
                sb        = b2[7];
                sr        = r[7];
            end
            xasf_pkg::SIZE_16:
            begin
                carry_out = sum[16];
                sa        = a[15];
                sb        = b2[15];
                sr        = r[15];
            end
            xasf_pkg::SIZE_32:
            begin
                carry_out = sum[32];
                sa        = a[31];
                sb        = b2[31];
                sr        = r[31];
            end
            default:
            begin
                carry_out = sum[64];
                sa        = a[63];
                sb        = b2[63];
                sr        = r[63];
            end
        endcase
    end

    always_comb
    begin
        res.result        = r;
        res.src_writeback = is_xadd ? a : '0;
        res.write_dest    = writes;
        res.write_src     = is_xadd;
        res.flag_carry    = carry_out ^ subtract;
        res.flag_overflow = (sa == sb) && (sr != sa);
        res.flag_aux      = a[4] ^ b[4] ^ r[4];
        res.flag_sign     = sr;
        res.flag_zero     = (r == '0);
        res.flag_parity   = ~^r[7:0];
    end

endmodule

`default_nettype wire

### hw/rtl/xasf_out_stage.sv
// Result register stage: captures one result item and holds it until the response side takes it.
// Depends on xasf_pkg and xasf_rsp_if.
`default_nettype none

module xasf_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire xasf_pkg::res_t res,
    input  wire logic           res_valid,
    output logic                res_ready,
    xasf_rsp_if.source          rsp
);

    xasf_pkg::res_t res_reg;
    logic           valid_reg;
    logic           valid_next;
    logic           load;

    assign res_ready  = !valid_reg || rsp.ready;
    assign load       = res_valid && res_ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.result        = res_reg.result;
    assign rsp.src_writeback = res_reg.src_writeback;
    assign rsp.write_dest    = res_reg.write_dest;
    assign rsp.write_src     = res_reg.write_src;
    assign rsp.flag_carry    = res_reg.flag_carry;
    assign rsp.flag_overflow = res_reg.flag_overflow;
    assign rsp.flag_aux      = res_reg.flag_aux;
    assign rsp.flag_sign     = res_reg.flag_sign;
    assign rsp.flag_zero     = res_reg.flag_zero;
    assign rsp.flag_parity   = res_reg.flag_parity;

endmodule

`default_nettype wire

### hw/rtl/xasf_chk.sv
// Port-level checker for the add/sub flags ALU, bound to the top level.
// Depends on x86_add_sub_flags_alu_defines.svh.
`default_nettype none

`include "x86_add_sub_flags_alu_defines.svh"

module xasf_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [63:0] result,
    input wire logic [63:0] src_writeback,
    input wire logic        write_dest,
    input wire logic        write_src,
    input wire logic        flag_zero,
    input wire logic        flag_parity
);

    // a stalled result stays presented
    `XASF_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid)

    // an accepted item passes both registers to the output if the output drains
    `XASF_ASSERT(a_latency, clk, rst_n, cmd_valid && cmd_ready ##1 rsp_ready |=> rsp_valid)

    // back-pressure only when the output is occupied
    `XASF_ASSERT_IMP(a_ready_full, clk, rst_n, !cmd_ready, rsp_valid)

    `XASF_ASSERT_IMP(a_zero_parity, clk, rst_n, rsp_valid,
        (flag_zero == (result == 64'd0)) && (flag_parity == ~^result[7:0]))

    `XASF_ASSERT_IMP(a_xadd_wb, clk, rst_n, rsp_valid,
        (write_src || (src_writeback == 64'd0)) && (!write_src || write_dest))

endmodule

bind x86_add_sub_flags_alu xasf_chk u_xasf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .result        (rsp.result),
    .src_writeback (rsp.src_writeback),
    .write_dest    (rsp.write_dest),
    .write_src     (rsp.write_src),
    .flag_zero     (rsp.flag_zero),
    .flag_parity   (rsp.flag_parity)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for x86_add_sub_flags_alu: bursty command driver, stalling
// response receiver, and an in-bench predictor of result, write enables and flags.
// Depends on xasf_pkg, xasf_cmd_if, xasf_rsp_if and the RTL of the block.
`timescale 1ns / 100ps

module tb;

    localparam logic [xasf_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [xasf_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;

    logic clk = 1'b0;
    logic rst_n;

    xasf_cmd_if cmd ();
    xasf_rsp_if rsp ();

    x86_add_sub_flags_alu i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    xasf_pkg::op_t  instr_q[$];
    xasf_pkg::res_t expected_results[$];
    xasf_pkg::op_t  next_instr;
    int   item_total;
    int   instr_sent   = 0;
    int   rsp_cnt      = 0;
    int   mismatch_cnt = 0;
    bit   cmd_fire     = 1'b0;
    int   burst_left   = 1;
    int   gap_left     = 0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    logic [15:0] stall_pat = '1;
    logic [3:0]  pat_pos   = '0;

    always #5 clk = ~clk;

    function automatic logic [xasf_pkg::DATA_W-1:0] width_mask(
            logic [xasf_pkg::SIZE_W-1:0] size_code);
        int w;
        w = 8 << size_code;
        return (w == xasf_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic xasf_pkg::res_t add_sub_result(xasf_pkg::op_t op);
        xasf_pkg::res_t   res;
        int               w;
        logic [63:0]      mask;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [63:0]      b_eff;
        logic [63:0]      r;
        logic [64:0]      sum;
        logic             subtract;
        logic             use_carry;
        logic             is_xadd;
        logic             cin;
        logic             cout;
        w         = 8 << op.size_code;
        mask      = width_mask(op.size_code);
        a         = op.dst_value & mask;
        b         = op.src_value & mask;
        subtract  = (op.mode == xasf_pkg::MODE_SUB) || (op.mode == xasf_pkg::MODE_SBB)
                    || (op.mode == xasf_pkg::MODE_CMP);
        use_carry = (op.mode == xasf_pkg::MODE_ADC) || (op.mode == xasf_pkg::MODE_SBB);
        is_xadd   = (op.mode == xasf_pkg::MODE_XADD);
        b_eff     = subtract ? (~b & mask) : b;
        if (subtract)
            cin = use_carry ? ~op.carry_in : 1'b1;
        else
            cin = use_carry ? op.carry_in : 1'b0;
        sum  = {1'b0, a} + {1'b0, b_eff} + {64'd0, cin};
        cout = sum[w];
        r    = sum[63:0] & mask;

        res.result        = r;
        res.src_writeback = is_xadd ? a : '0;
        res.write_dest    = (op.mode == xasf_pkg::MODE_ADD) || (op.mode == xasf_pkg::MODE_ADC)
                            || (op.mode == xasf_pkg::MODE_SUB)
                            || (op.mode == xasf_pkg::MODE_SBB) || is_xadd;
        res.write_src     = is_xadd;
        res.flag_carry    = subtract ? ~cout : cout;
        res.flag_overflow = (a[w-1] == b_eff[w-1]) && (r[w-1] != a[w-1]);
        res.flag_aux      = a[4] ^ b[4] ^ r[4];
        res.flag_sign     = r[w-1];
        res.flag_zero     = (r == '0);
        res.flag_parity   = ~^r[7:0];
        return res;
    endfunction

    function automatic xasf_pkg::op_t make_instr(logic [xasf_pkg::MODE_W-1:0] mode,
                                                 logic [xasf_pkg::SIZE_W-1:0] size_code,
                                                 logic [63:0] dst, logic [63:0] src,
                                                 logic cin);
        xasf_pkg::op_t op;
        op.mode      = mode;
        op.size_code = size_code;
        op.dst_value = dst;
        op.src_value = src;
        op.carry_in  = cin;
        return op;
    endfunction

    function automatic logic [63:0] pick_operand(logic [xasf_pkg::SIZE_W-1:0] size_code);
        logic [63:0] mask;
        logic [63:0] v;
        mask = width_mask(size_code);
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = 64'd1;
            2:       v = mask;
            3:       v = mask >> 1;
            4:       v = (mask >> 1) + 64'd1;
            5:       v = 64'($urandom_range(0, 31));
            default: v = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 1) == 1)
            v = v | ({$urandom, $urandom} & ~mask);
        return v;
    endfunction

    function automatic xasf_pkg::op_t random_instr();
        xasf_pkg::op_t op;
        logic [31:0]   sz;
        case ($urandom_range(0, 13))
            0, 1:    op.mode = xasf_pkg::MODE_ADD;
            2, 3:    op.mode = xasf_pkg::MODE_ADC;
            4, 5:    op.mode = xasf_pkg::MODE_SUB;
            6, 7:    op.mode = xasf_pkg::MODE_SBB;
            8, 9:    op.mode = xasf_pkg::MODE_CMP;
            10, 11:  op.mode = xasf_pkg::MODE_XADD;
            12:      op.mode = MODE_RSVD6;
            default: op.mode = MODE_RSVD7;
        endcase
        sz           = $urandom_range(0, 3);
        op.size_code = sz[xasf_pkg::SIZE_W-1:0];
        op.dst_value = pick_operand(op.size_code);
        op.src_value = ($urandom_range(0, 7) == 0) ? op.dst_value
                                                    : pick_operand(op.size_code);
        op.carry_in  = 1'($urandom_range(0, 1));
        return op;
    endfunction

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("item %0d %s: expected %h, got %h", rsp_cnt, field, want, got);
        end
    endtask

    // Driver: bursts of items with random gaps; hold the item until accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else if (!cmd.valid || cmd_fire)
        begin
            if (gap_left > 0 || instr_q.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                cmd.valid <= 1'b0;
            end
            else
            begin
                next_instr = instr_q.pop_front();
                cmd.valid     <= 1'b1;
                cmd.mode      <= next_instr.mode;
                cmd.size_code <= next_instr.size_code;
                cmd.dst_value <= next_instr.dst_value;
                cmd.src_value <= next_instr.src_value;
                cmd.carry_in  <= next_instr.carry_in;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else if (!hold_done && rsp_cnt >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (pat_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom | $urandom);
                    default: stall_pat = 16'($urandom & $urandom);
                endcase
            end
            rsp.ready <= stall_pat[pat_pos];
            pat_pos = pat_pos + 4'd1;
        end
    end

    // Monitor: check results in order, then record the item just taken.
    always @(posedge clk)
    begin
        xasf_pkg::res_t want;
        xasf_pkg::op_t  taken;
        cmd_fire = rst_n && cmd.valid && cmd.ready;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("item %0d: result with no item outstanding", rsp_cnt);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result", rsp.result, want.result);
                check_field("src_writeback", rsp.src_writeback, want.src_writeback);
                check_field("write_dest", rsp.write_dest, want.write_dest);
                check_field("write_src", rsp.write_src, want.write_src);
                check_field("flag_carry", rsp.flag_carry, want.flag_carry);
                check_field("flag_overflow", rsp.flag_overflow, want.flag_overflow);
                check_field("flag_aux", rsp.flag_aux, want.flag_aux);
                check_field("flag_sign", rsp.flag_sign, want.flag_sign);
                check_field("flag_zero", rsp.flag_zero, want.flag_zero);
                check_field("flag_parity", rsp.flag_parity, want.flag_parity);
            end
            rsp_cnt++;
        end
        if (cmd_fire)
        begin
            taken = make_instr(cmd.mode, cmd.size_code, cmd.dst_value, cmd.src_value,
                               cmd.carry_in);
            expected_results.push_back(add_sub_result(taken));
            instr_sent++;
        end
    end

    initial
    begin
        int n;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.mode      = xasf_pkg::MODE_ADD;
        cmd.size_code = xasf_pkg::SIZE_8;
        cmd.dst_value = '0;
        cmd.src_value = '0;
        cmd.carry_in  = 1'b0;
        rsp.ready     = 1'b0;

        instr_q.push_back(make_instr(xasf_pkg::MODE_ADD, xasf_pkg::SIZE_8, 64'h7F, 64'h01,
                                     1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADD, xasf_pkg::SIZE_8,
                                     64'hA5A5_A5A5_A5A5_A5FF, 64'h5A5A_5A5A_5A5A_5A01, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADC, xasf_pkg::SIZE_16, 64'hFFFF, 64'h0,
                                     1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADC, xasf_pkg::SIZE_16, 64'h7FFF, 64'h0,
                                     1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SUB, xasf_pkg::SIZE_32, 64'h0, 64'h1,
                                     1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SUB, xasf_pkg::SIZE_32, 64'h8000_0000,
                                     64'h1, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SBB, xasf_pkg::SIZE_64, 64'h0, 64'h0,
                                     1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SBB, xasf_pkg::SIZE_64,
                                     64'h8000_0000_0000_0000, 64'h0, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SBB, xasf_pkg::SIZE_8, 64'h10, 64'h0F,
                                     1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_CMP, xasf_pkg::SIZE_64,
                                     64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_CMP, xasf_pkg::SIZE_8, 64'h0,
                                     64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_CMP, xasf_pkg::SIZE_16, 64'h8000,
                                     64'h7FFF, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_XADD, xasf_pkg::SIZE_32, 64'hFFFF_FFFF,
                                     64'h1, 1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_XADD, xasf_pkg::SIZE_64,
                                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_XADD, xasf_pkg::SIZE_8,
                                     64'hFFFF_0000_0000_000F, 64'h01, 1'b0));
        instr_q.push_back(make_instr(MODE_RSVD6, xasf_pkg::SIZE_16, 64'h8000, 64'h8000, 1'b0));
        instr_q.push_back(make_instr(MODE_RSVD7, xasf_pkg::SIZE_64, 64'h7FFF_FFFF_FFFF_FFFF,
                                     64'h1, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADD, xasf_pkg::SIZE_64, 64'h0, 64'h0,
                                     1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADC, xasf_pkg::SIZE_64,
                                     64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1));
        instr_q.push_back(make_instr(xasf_pkg::MODE_SUB, xasf_pkg::SIZE_16, 64'h10, 64'h01,
                                     1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADD, xasf_pkg::SIZE_32, 64'h7FFF_FFFF,
                                     64'h7FFF_FFFF, 1'b0));
        instr_q.push_back(make_instr(xasf_pkg::MODE_ADC, xasf_pkg::SIZE_8, 64'hFF, 64'hFF,
                                     1'b1));
        for (n = 0; n < RANDOM_ITEMS; n++)
            instr_q.push_back(random_instr());
        item_total = instr_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (instr_sent == item_total);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASS x86_add_sub_flags_alu");
        else
            $display("FAIL x86_add_sub_flags_alu");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL x86_add_sub_flags_alu");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/xasf_pkg.sv
hw/rtl/xasf_cmd_if.sv
hw/rtl/xasf_rsp_if.sv
hw/rtl/xasf_in_stage.sv
hw/rtl/xasf_exec.sv
hw/rtl/xasf_out_stage.sv
hw/rtl/x86_add_sub_flags_alu.sv
hw/rtl/xasf_chk.sv
tb/tb.sv
